### rtl/core/upe_pkg.sv
// ----------------------------------------------------------------------------
// upe_pkg
// Shared types, status codes and byte helpers for the url path encoder.
// ----------------------------------------------------------------------------
package upe_pkg;

  // terminator status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StOutOvf  = 2'd1;
  localparam logic [1:0] StInLong  = 2'd2;

  // special characters
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChNul     = 8'h00;

  // results caused by one input item, up to three bytes
  typedef struct packed {
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [1:0] cnt;
    logic       eos;
    logic [1:0] status;
  } res_t;

  // allowed set: letters, '!'..';' except quote and percent, '=', '~', '_'
  function automatic logic allowed_f(input logic [7:0] b);
    logic ok;
    ok = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
         (b >= 8'h21 && b <= 8'h3B) || b == 8'h3D || b == 8'h7E || b == 8'h5F;
    return ok && b != ChQuote && b != ChPercent;
  endfunction

  // uppercase hex digit of a nibble
  function automatic logic [7:0] hex_f(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = 8'h30 + {4'd0, v};
    end else begin
      d = 8'h37 + {4'd0, v};
    end
    return d;
  endfunction

endpackage

### rtl/core/upe_step.sv
// ----------------------------------------------------------------------------
// upe_step
// String state and per-byte encoding decision for the url path encoder.
// ----------------------------------------------------------------------------
module upe_step
  import upe_pkg::*;
#(
  parameter int MAX_INPUT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] cap_i,
  output res_t        res_o
);

  localparam int CntW = $clog2(MAX_INPUT + 2);
  localparam logic [CntW-1:0] MaxIn = CntW'(MAX_INPUT);

  logic [1:0]      slash_q, slash_d;
  logic [15:0]     oc_q, oc_d;
  logic [CntW-1:0] ic_q, ic_d;
  logic            disc_q, disc_d;

  logic [16:0] oc_p1, oc_p3, cap_x;
  logic        pass;

  assign oc_p1 = {1'b0, oc_q} + 17'd1;
  assign oc_p3 = {1'b0, oc_q} + 17'd3;
  assign cap_x = {1'b0, cap_i};
  assign pass  = (slash_q != 2'd3) || allowed_f(byte_i);

  // encoding decision for the byte in the input register
  always_comb begin
    slash_d = slash_q;
    oc_d    = oc_q;
    ic_d    = ic_q;
    disc_d  = disc_q;
    res_o   = '{data0: ChNul, data1: ChNul, data2: ChNul, cnt: 2'd0,
                eos: 1'b0, status: StOk};
    if (disc_q) begin
      if (byte_i == ChNul) begin
        disc_d  = 1'b0;
        slash_d = '0;
        oc_d    = '0;
        ic_d    = '0;
      end
    end else if (ic_q > MaxIn || byte_i == ChNul || (pass && oc_p1 >= cap_x) ||
                 (!pass && oc_p3 >= cap_x)) begin
      // terminator ends the string
      res_o.cnt = 2'd1;
      res_o.eos = 1'b1;
      slash_d   = '0;
      oc_d      = '0;
      ic_d      = '0;
      if (ic_q > MaxIn) begin
        res_o.status = StInLong;
        disc_d       = (byte_i != ChNul);
      end else if (byte_i == ChNul) begin
        res_o.status = StOk;
      end else begin
        res_o.status = StOutOvf;
        disc_d       = 1'b1;
      end
    end else if (pass) begin
      res_o.data0 = byte_i;
      res_o.cnt   = 2'd1;
      ic_d        = ic_q + CntW'(1);
      oc_d        = oc_p1[15:0];
      if (slash_q != 2'd3 && byte_i == ChSlash) begin
        slash_d = slash_q + 2'd1;
      end
    end else begin
      // percent escape
      res_o.data0 = ChPercent;
      res_o.data1 = hex_f(byte_i[7:4]);
      res_o.data2 = hex_f(byte_i[3:0]);
      res_o.cnt   = 2'd3;
      ic_d        = ic_q + CntW'(1);
      oc_d        = oc_p3[15:0];
    end
  end

  // string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slash_q <= '0;
      oc_q    <= '0;
      ic_q    <= '0;
      disc_q  <= 1'b0;
    end else if (step_i) begin
      slash_q <= slash_d;
      oc_q    <= oc_d;
      ic_q    <= ic_d;
      disc_q  <= disc_d;
    end
  end

  // the input index never runs past one beyond the limit
  a_ic_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ic_q <= MaxIn + CntW'(1))
    else $error("input index out of range");

  // a terminator always clears the string state
  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.eos |=> oc_q == '0 && ic_q == '0 && slash_q == '0)
    else $error("string state not cleared by terminator");

  // nothing is emitted while dropping input
  a_disc_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> res_o.cnt == 2'd0)
    else $error("result while discarding");

endmodule

### rtl/core/url_path_percent_encoder.sv
// ----------------------------------------------------------------------------
// url_path_percent_encoder
// Percent encoder for url paths with output capacity and input length limits.
// ----------------------------------------------------------------------------
// Path: an item's input transfer fills the input register; its results are offered
// from the result buffer once the step loads it, which waits for the buffer to free.
// Throughput: one item per cycle while each item gives at most one result and the
// output is ready; an escaped byte gives three bytes on the one-byte result port.
// Reset: string state cleared, discarding off, out_capacity set to 1024.
module url_path_percent_encoder
  import upe_pkg::*;
#(
  parameter int MAX_INPUT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        end_of_string_o,
  output logic [1:0]  status_o
);

  localparam logic RegOutCap = 1'b0;

  logic [15:0] cap_q;
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  res_t        res, buf_q;
  logic        load, out_acc, in_acc;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegOutCap) ? {16'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'd1024;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegOutCap) begin
      cap_q <= pwdata[15:0];
    end
  end

  // handshake control
  assign out_valid_o = (buf_q.cnt != 2'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign load        = in_vld_q && (buf_q.cnt == 2'd0 || (buf_q.cnt == 2'd1 && out_ready_i));
  assign in_ready_o  = !in_vld_q || load;
  assign in_acc      = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (load) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_byte_i;
    end
  end

  // encoding step
  upe_step #(
    .MAX_INPUT (MAX_INPUT)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (load),
    .byte_i (in_byte_q),
    .cap_i  (cap_q),
    .res_o  (res)
  );

  // result buffer, shifts one byte per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '{data0: ChNul, data1: ChNul, data2: ChNul, cnt: 2'd0,
                 eos: 1'b0, status: StOk};
    end else if (load) begin
      buf_q <= res;
    end else if (out_acc) begin
      buf_q.data0 <= buf_q.data1;
      buf_q.data1 <= buf_q.data2;
      buf_q.cnt   <= buf_q.cnt - 2'd1;
    end
  end

  assign out_byte_o      = buf_q.data0;
  assign end_of_string_o = buf_q.eos;
  assign status_o        = buf_q.eos ? buf_q.status : StOk;

  // a terminator is always a lone result
  a_eos_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_string_o |-> buf_q.cnt == 2'd1 && out_byte_o == ChNul)
    else $error("terminator not alone or nonzero");

  // a new item only enters the buffer once the old results are gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> buf_q.cnt == 2'd0 || (buf_q.cnt == 2'd1 && out_ready_i))
    else $error("result buffer overwritten");

  // a waiting input item is held until processed
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !load |=> in_vld_q && $stable(in_byte_q))
    else $error("pending item lost");

endmodule
